@@ rtl/psp_pkg.sv @@
package psp_pkg;

    // Number of light fields carried by one input request.
    localparam int LIGHT_FIELDS = 6;
    // Width of one scaled normal component b.
    localparam int BW = 28;
    // Width of the squared length and of the square root working registers.
    localparam int SW = 56;
    // Width of the rounded length.
    localparam int LW = 28;
    // Shared divider: dividend and divisor widths.
    localparam int NUMW = 42;
    localparam int DENW = 28;
    // Width of a slope in Q16.12.
    localparam int SLW = 28;

    localparam logic [15:0] Q14_ONE = 16'd16384;
    localparam logic [21:0] ALBEDO_MAX = 22'h3FFFFF;
    localparam logic signed [31:0] SAT_MAX = 32'sh7FFFFFFF;

    // Configuration register indexes.
    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_DIVISOR = 2'd1;

    // Request kinds on the input stream.
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC,
        ST_SQ,
        ST_SQRT_GO,
        ST_SQRT,
        ST_NDIV,
        ST_NWAIT,
        ST_SDIV,
        ST_SWAIT,
        ST_CALC,
        ST_DDIV,
        ST_DWAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic            start;
        logic [NUMW-1:0] num;
        logic [DENW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic            done;
        logic [NUMW-1:0] quot;
    } div_rsp_t;

    // Color channel: 127 * n + 127, rounded half up, limited to 255.
    function automatic logic [7:0] color_of(input logic signed [15:0] n);
        logic signed [23:0] t;
        logic [9:0] c;
        t = 24'sd127 * 24'(n) + 24'sd2080768 + 24'sd8192;
        c = t[23:14];
        return (c > 10'd255) ? 8'd255 : c[7:0];
    endfunction

    // Saturate a 33-bit difference to +-(2^31 - 1).
    function automatic logic signed [31:0] sat33(input logic signed [32:0] d);
        logic signed [32:0] hi;
        hi = 33'(SAT_MAX);
        if (d > hi)
        begin
            return SAT_MAX;
        end
        else if (d < -hi)
        begin
            return -SAT_MAX;
        end
        return d[31:0];
    endfunction

endpackage

@@ rtl/psp_mac.sv @@
// Coefficient memory and multiply-accumulate unit for the scaled normal b.
module psp_mac #(
    parameter int LIGHT_COUNT = 6
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      load_en,
    input  logic [4:0]                                load_addr,
    input  logic [15:0]                               load_data,
    input  logic                                      start,
    input  logic [psp_pkg::LIGHT_FIELDS-1:0][7:0]     lights,
    output logic                                      done,
    output logic [2:0][psp_pkg::BW-1:0]               b
);

    localparam int SLOTS = 3 * LIGHT_COUNT;
    localparam int AW = $clog2(SLOTS);
    localparam int LU = (LIGHT_COUNT < psp_pkg::LIGHT_FIELDS) ? LIGHT_COUNT
                                                              : psp_pkg::LIGHT_FIELDS;
    localparam int LI = $clog2(psp_pkg::LIGHT_FIELDS);

    logic [15:0] coef_mem [SLOTS];
    logic [15:0] rd_reg;
    logic issue_reg;
    logic pend_reg;
    logic done_reg;
    logic [1:0] row_reg;
    logic [1:0] pend_row_reg;
    logic [LI-1:0] light_reg;
    logic [LI-1:0] pend_light_reg;
    logic [AW-1:0] base_reg;
    logic signed [psp_pkg::BW-1:0] acc_reg [3];

    logic last_issue;
    logic row_end;
    logic load_ok;
    logic [AW-1:0] rd_addr;
    logic signed [24:0] prod;

    assign row_end = (light_reg == LI'(LU - 1));
    assign last_issue = (row_reg == 2'd2) && row_end;
    assign rd_addr = base_reg + AW'(light_reg);
    assign load_ok = ({27'd0, load_addr} < 32'(SLOTS));
    assign prod = $signed(rd_reg) * $signed({1'b0, lights[pend_light_reg]});

    // Read sequencer: one coefficient per cycle, row by row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg <= 1'b0;
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
            row_reg <= '0;
            light_reg <= '0;
            base_reg <= '0;
            pend_row_reg <= '0;
            pend_light_reg <= '0;
        end
        else
        begin
            pend_reg <= issue_reg;
            pend_row_reg <= row_reg;
            pend_light_reg <= light_reg;
            done_reg <= pend_reg && (pend_row_reg == 2'd2) && (pend_light_reg == LI'(LU - 1));
            if (start)
            begin
                issue_reg <= 1'b1;
                row_reg <= '0;
                light_reg <= '0;
                base_reg <= '0;
            end
            else if (issue_reg)
            begin
                if (last_issue)
                begin
                    issue_reg <= 1'b0;
                end
                else if (row_end)
                begin
                    light_reg <= '0;
                    row_reg <= row_reg + 2'd1;
                    base_reg <= base_reg + AW'(LIGHT_COUNT);
                end
                else
                begin
                    light_reg <= light_reg + LI'(1);
                end
            end
        end
    end

    // Coefficient memory, registered read data and the accumulators.
    always_ff @(posedge clk)
    begin
        if (load_en && load_ok)
        begin
            coef_mem[load_addr[AW-1:0]] <= load_data;
        end
        if (issue_reg)
        begin
            rd_reg <= coef_mem[rd_addr];
        end
        if (start)
        begin
            acc_reg[0] <= '0;
            acc_reg[1] <= '0;
            acc_reg[2] <= '0;
        end
        else if (pend_reg)
        begin
            acc_reg[pend_row_reg] <= acc_reg[pend_row_reg] + psp_pkg::BW'(prod);
        end
    end

    assign done = done_reg;
    assign b[0] = acc_reg[0];
    assign b[1] = acc_reg[1];
    assign b[2] = acc_reg[2];

endmodule

@@ rtl/psp_sqrt.sv @@
// Square root, two radicand bits per cycle, rounded to nearest.
module psp_sqrt (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [psp_pkg::SW-1:0]  s_in,
    output logic                    done,
    output logic [psp_pkg::LW-1:0]  root
);

    logic [psp_pkg::SW-1:0] rem_reg;
    logic [psp_pkg::SW-1:0] r_reg;
    logic [psp_pkg::SW-1:0] bit_reg;
    logic busy_reg;
    logic done_reg;
    logic [psp_pkg::SW-1:0] trial;
    logic take;

    assign trial = r_reg + bit_reg;
    assign take = (rem_reg >= trial);

    // Control: busy until the lowest bit position has been handled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && bit_reg[0];
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // One restoring step per cycle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= s_in;
            r_reg <= '0;
            bit_reg <= {2'b01, {(psp_pkg::SW - 2){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                rem_reg <= rem_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[psp_pkg::LW-1:0] + psp_pkg::LW'(rem_reg > r_reg);

endmodule

@@ rtl/psp_div.sv @@
// Unsigned restoring divider, one quotient bit per cycle.
module psp_div (
    input  logic              clk,
    input  logic              rst_n,
    input  psp_pkg::div_req_t req,
    output psp_pkg::div_rsp_t rsp
);

    localparam int CNTW = $clog2(psp_pkg::NUMW + 1);

    logic [psp_pkg::NUMW-1:0] num_reg;
    logic [psp_pkg::NUMW-1:0] quot_reg;
    logic [psp_pkg::DENW-1:0] den_reg;
    logic [psp_pkg::DENW-1:0] rem_reg;
    logic [CNTW-1:0] cnt_reg;
    logic busy_reg;
    logic done_reg;
    logic [psp_pkg::DENW:0] trial;
    logic [psp_pkg::DENW:0] diff;
    logic fits;

    assign trial = {rem_reg, num_reg[psp_pkg::NUMW-1]};
    assign diff = trial - {1'b0, den_reg};
    assign fits = (trial >= {1'b0, den_reg});

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CNTW'(psp_pkg::NUMW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift the dividend in and build the quotient.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= fits ? diff[psp_pkg::DENW-1:0] : trial[psp_pkg::DENW-1:0];
            quot_reg <= {quot_reg[psp_pkg::NUMW-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

@@ rtl/photometric_stereo_pixel_core.sv @@
// Channel   | Direction | Signals                              | Content
// s_axis    | in        | tvalid tready tdata[71:0] tuser[1:0] | pixel or coefficient load
// m_axis    | out       | tvalid tready tdata[127:0] tuser[0]  | normal, albedo, color, depth
// cfg       | in        | valid ready index[1:0] data[8:0]     | register write
//
// Pixel time is set by the shared bit-serial divider (up to three normals, two slopes, one depth)
// and the two-bit-per-cycle square root; the next pixel is accepted only after the result is loaded.
// A coefficient load is written to the coefficient memory as it is accepted.
// Reset clears the counters, the running left sum and the first-row flag;
// the coefficient memory and the column line memory hold nothing until written.
// A result waiting on m_axis stalls only the final output load.
module photometric_stereo_pixel_core #(
    parameter int MAX_COLUMNS = 256,
    parameter int LIGHT_COUNT = 6
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // coef_index, coef_value, light_0 .. light_5, zero fill
    input  logic [71:0]  s_axis_tdata,
    // mode, frame_start
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // normal_x, normal_y, normal_z, albedo, color_x, color_y, color_z, depth, zero fill
    output logic [127:0] m_axis_tdata,
    // flat_pixel
    output logic [0:0]   m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [8:0]   cfg_data
);

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int EW = (CW + 1 > 10) ? CW + 1 : 10;

    // Input fields.
    logic in_mode;
    logic in_frame;
    logic [4:0] in_coef_index;
    logic [15:0] in_coef_value;
    logic [psp_pkg::LIGHT_FIELDS-1:0][7:0] in_lights;

    always_comb
    begin
        for (int i = 0; i < psp_pkg::LIGHT_FIELDS; i++)
        begin
            in_lights[i] = s_axis_tdata[21 + 8 * i +: 8];
        end
    end
    assign in_mode = s_axis_tuser[0];
    assign in_frame = s_axis_tuser[1];
    assign in_coef_index = s_axis_tdata[4:0];
    assign in_coef_value = s_axis_tdata[20:5];

    // Registers.
    psp_pkg::state_t state_reg;
    psp_pkg::state_t state_next;
    logic [8:0] cols_reg;
    logic [7:0] div_reg;
    logic [1:0] k_reg;
    logic [CW-1:0] col_cnt_reg;
    logic [CW-1:0] c_reg;
    logic first_row_reg;
    logic first_reg;
    logic signed [31:0] left_reg;
    logic [psp_pkg::LIGHT_FIELDS-1:0][7:0] lights_reg;
    logic [psp_pkg::SW-1:0] s_reg;
    logic [psp_pkg::LW-1:0] len_reg;
    logic signed [15:0] n_reg [3];
    logic signed [psp_pkg::SLW-1:0] slope_reg [2];
    logic flat_reg;
    logic [30:0] mag_reg;
    logic [30:0] depth_reg;
    logic m_valid_reg;
    logic [127:0] out_data_reg;
    logic out_flat_reg;
    logic [31:0] line_mem [MAX_COLUMNS];
    logic [31:0] line_rd_reg;

    // Strobes and datapath wires.
    logic accept;
    logic pix_accept;
    logic load_accept;
    logic mac_start;
    logic mac_done;
    logic sqrt_start;
    logic sqrt_done;
    logic out_load;
    logic [psp_pkg::LW-1:0] sqrt_root;
    logic [2:0][psp_pkg::BW-1:0] b_vec;
    psp_pkg::div_req_t div_req;
    psp_pkg::div_rsp_t div_rsp;
    logic [CW-1:0] c_start;

    logic signed [psp_pkg::BW-1:0] b_sel;
    logic [psp_pkg::BW-1:0] b_abs;
    logic signed [2*psp_pkg::BW-1:0] b_sq;
    logic [15:0] n_mag;
    logic signed [15:0] n_new;
    logic signed [15:0] n_sel;
    logic [15:0] n_abs;
    logic [15:0] nz_abs;
    logic [psp_pkg::SLW-1:0] q_slope;
    logic signed [psp_pkg::SLW-1:0] slope_new;
    logic [psp_pkg::NUMW-1:0] ndiv_num;
    logic [psp_pkg::NUMW-1:0] sdiv_num;
    logic [psp_pkg::NUMW-1:0] ddiv_num;
    logic [7:0] div_eff;
    logic signed [32:0] d_col;
    logic signed [32:0] d_sum;
    logic signed [31:0] left_in;
    logic signed [31:0] col_val;
    logic signed [31:0] sum_val;
    logic [31:0] sum_abs;
    logic [EW-1:0] cols_ext;
    logic [EW-1:0] eff;
    logic [EW-1:0] c_plus;
    logic [21:0] albedo_val;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign pix_accept = accept && (in_mode == psp_pkg::MODE_PIXEL);
    assign load_accept = accept && (in_mode == psp_pkg::MODE_LOAD);
    assign c_start = in_frame ? '0 : col_cnt_reg;
    assign cfg_ready = 1'b1;

    psp_mac #(
        .LIGHT_COUNT(LIGHT_COUNT)
    ) u_mac (
        .clk(clk),
        .rst_n(rst_n),
        .load_en(load_accept),
        .load_addr(in_coef_index),
        .load_data(in_coef_value),
        .start(mac_start),
        .lights(lights_reg),
        .done(mac_done),
        .b(b_vec)
    );

    psp_sqrt u_sqrt (
        .clk(clk),
        .rst_n(rst_n),
        .start(sqrt_start),
        .s_in(s_reg),
        .done(sqrt_done),
        .root(sqrt_root)
    );

    psp_div u_div (
        .clk(clk),
        .rst_n(rst_n),
        .req(div_req),
        .rsp(div_rsp)
    );

    // Normal division operands and result.
    always_comb
    begin
        b_sel = $signed(b_vec[k_reg]);
        b_abs = b_sel[psp_pkg::BW-1] ? psp_pkg::BW'(-b_sel) : psp_pkg::BW'(b_sel);
        b_sq = b_sel * b_sel;
        ndiv_num = (psp_pkg::NUMW'(b_abs) << 14) + psp_pkg::NUMW'(len_reg >> 1);
        n_mag = (div_rsp.quot > psp_pkg::NUMW'(psp_pkg::Q14_ONE)) ? psp_pkg::Q14_ONE
                                                                  : div_rsp.quot[15:0];
        n_new = b_sel[psp_pkg::BW-1] ? -$signed(n_mag) : $signed(n_mag);
    end

    // Slope division operands and result.
    always_comb
    begin
        n_sel = n_reg[k_reg];
        n_abs = n_sel[15] ? 16'(-n_sel) : 16'(n_sel);
        nz_abs = n_reg[2][15] ? 16'(-n_reg[2]) : 16'(n_reg[2]);
        sdiv_num = (psp_pkg::NUMW'(n_abs) << 12) + psp_pkg::NUMW'(nz_abs >> 1);
        q_slope = div_rsp.quot[psp_pkg::SLW-1:0];
        slope_new = (n_sel[15] ^ n_reg[2][15]) ? -$signed(q_slope) : $signed(q_slope);
    end

    // Column and depth sums with saturation.
    always_comb
    begin
        d_col = 33'($signed(line_rd_reg)) - 33'(slope_reg[0]);
        col_val = (flat_reg || first_reg) ? 32'sd0 : psp_pkg::sat33(d_col);
        left_in = (c_reg == '0) ? 32'sd0 : left_reg;
        d_sum = 33'(left_in) - 33'(slope_reg[1]);
        sum_val = flat_reg ? 32'sd0 : psp_pkg::sat33(d_sum);
        sum_abs = sum_val[31] ? 32'(-sum_val) : 32'(sum_val);
        div_eff = (div_reg == 8'd0) ? 8'd1 : div_reg;
        ddiv_num = psp_pkg::NUMW'(mag_reg) + psp_pkg::NUMW'(div_eff >> 1);
        cols_ext = EW'(cols_reg);
        if (cols_ext == '0)
        begin
            eff = EW'(1);
        end
        else if (cols_ext > EW'(MAX_COLUMNS))
        begin
            eff = EW'(MAX_COLUMNS);
        end
        else
        begin
            eff = cols_ext;
        end
        c_plus = EW'(c_reg) + EW'(1);
        albedo_val = (len_reg > psp_pkg::LW'(psp_pkg::ALBEDO_MAX)) ? psp_pkg::ALBEDO_MAX
                                                                    : len_reg[21:0];
    end

    // Sequencer: next state and unit strobes.
    always_comb
    begin
        state_next = state_reg;
        s_axis_tready = 1'b0;
        mac_start = 1'b0;
        sqrt_start = 1'b0;
        out_load = 1'b0;
        div_req.start = 1'b0;
        div_req.num = '0;
        div_req.den = '0;
        case (state_reg)
            psp_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (pix_accept)
                begin
                    mac_start = 1'b1;
                    state_next = psp_pkg::ST_MAC;
                end
            end
            psp_pkg::ST_MAC:
            begin
                if (mac_done)
                begin
                    state_next = psp_pkg::ST_SQ;
                end
            end
            psp_pkg::ST_SQ:
            begin
                if (k_reg == 2'd2)
                begin
                    state_next = psp_pkg::ST_SQRT_GO;
                end
            end
            psp_pkg::ST_SQRT_GO:
            begin
                sqrt_start = 1'b1;
                state_next = psp_pkg::ST_SQRT;
            end
            psp_pkg::ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = (sqrt_root == '0) ? psp_pkg::ST_CALC : psp_pkg::ST_NDIV;
                end
            end
            psp_pkg::ST_NDIV:
            begin
                div_req.start = 1'b1;
                div_req.num = ndiv_num;
                div_req.den = psp_pkg::DENW'(len_reg);
                state_next = psp_pkg::ST_NWAIT;
            end
            psp_pkg::ST_NWAIT:
            begin
                if (div_rsp.done)
                begin
                    if (k_reg == 2'd2)
                    begin
                        state_next = (n_new == 16'sd0) ? psp_pkg::ST_CALC : psp_pkg::ST_SDIV;
                    end
                    else
                    begin
                        state_next = psp_pkg::ST_NDIV;
                    end
                end
            end
            psp_pkg::ST_SDIV:
            begin
                div_req.start = 1'b1;
                div_req.num = sdiv_num;
                div_req.den = psp_pkg::DENW'(nz_abs);
                state_next = psp_pkg::ST_SWAIT;
            end
            psp_pkg::ST_SWAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = (k_reg == 2'd1) ? psp_pkg::ST_CALC : psp_pkg::ST_SDIV;
                end
            end
            psp_pkg::ST_CALC:
            begin
                state_next = flat_reg ? psp_pkg::ST_OUT : psp_pkg::ST_DDIV;
            end
            psp_pkg::ST_DDIV:
            begin
                div_req.start = 1'b1;
                div_req.num = ddiv_num;
                div_req.den = psp_pkg::DENW'(div_eff);
                state_next = psp_pkg::ST_DWAIT;
            end
            psp_pkg::ST_DWAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = psp_pkg::ST_OUT;
                end
            end
            psp_pkg::ST_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_load = 1'b1;
                    state_next = psp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psp_pkg::ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control state: configuration, position in the frame, step counter, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= 9'd120;
            div_reg <= 8'd20;
            col_cnt_reg <= '0;
            first_row_reg <= 1'b1;
            left_reg <= '0;
            k_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    psp_pkg::CFG_COLUMNS: cols_reg <= cfg_data;
                    psp_pkg::CFG_DIVISOR: div_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (pix_accept && in_frame)
            begin
                col_cnt_reg <= '0;
                first_row_reg <= 1'b1;
                left_reg <= '0;
            end
            if (state_reg == psp_pkg::ST_CALC)
            begin
                left_reg <= col_val;
                if (c_plus >= eff)
                begin
                    col_cnt_reg <= '0;
                    first_row_reg <= 1'b0;
                end
                else
                begin
                    col_cnt_reg <= c_plus[CW-1:0];
                end
            end
            if (mac_done || (state_reg == psp_pkg::ST_SQRT && sqrt_done))
            begin
                k_reg <= '0;
            end
            else if (state_reg == psp_pkg::ST_SQ)
            begin
                k_reg <= k_reg + 2'd1;
            end
            else if ((state_reg == psp_pkg::ST_NWAIT || state_reg == psp_pkg::ST_SWAIT)
                     && div_rsp.done)
            begin
                k_reg <= (state_reg == psp_pkg::ST_NWAIT && k_reg == 2'd2) ? 2'd0
                                                                           : k_reg + 2'd1;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Per-pixel datapath registers and the column line memory.
    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            lights_reg <= in_lights;
            c_reg <= c_start;
            first_reg <= in_frame | first_row_reg;
            line_rd_reg <= line_mem[c_start];
        end
        if (state_reg == psp_pkg::ST_MAC && mac_done)
        begin
            s_reg <= '0;
        end
        if (state_reg == psp_pkg::ST_SQ)
        begin
            s_reg <= s_reg + psp_pkg::SW'(b_sq);
        end
        if (state_reg == psp_pkg::ST_SQRT && sqrt_done)
        begin
            len_reg <= sqrt_root;
            flat_reg <= (sqrt_root == '0);
            n_reg[0] <= '0;
            n_reg[1] <= '0;
            n_reg[2] <= '0;
            slope_reg[0] <= '0;
            slope_reg[1] <= '0;
        end
        if (state_reg == psp_pkg::ST_NWAIT && div_rsp.done)
        begin
            n_reg[k_reg] <= n_new;
            if (k_reg == 2'd2)
            begin
                flat_reg <= (n_new == 16'sd0);
            end
        end
        if (state_reg == psp_pkg::ST_SWAIT && div_rsp.done)
        begin
            slope_reg[k_reg[0]] <= slope_new;
        end
        if (state_reg == psp_pkg::ST_CALC)
        begin
            line_mem[c_reg] <= col_val;
            mag_reg <= sum_abs[30:0];
            depth_reg <= '0;
        end
        if (state_reg == psp_pkg::ST_DWAIT && div_rsp.done)
        begin
            depth_reg <= div_rsp.quot[30:0];
        end
        if (out_load)
        begin
            out_data_reg <= {3'b000, depth_reg,
                             psp_pkg::color_of(n_reg[2]),
                             psp_pkg::color_of(n_reg[1]),
                             psp_pkg::color_of(n_reg[0]),
                             albedo_val, n_reg[2], n_reg[1], n_reg[0]};
            out_flat_reg <= flat_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata = out_data_reg;
    assign m_axis_tuser[0] = out_flat_reg;

    // The coefficient unit finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> state_reg == psp_pkg::ST_MAC)
        else $error("coefficient unit finished outside its wait state");

    // The square root finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> state_reg == psp_pkg::ST_SQRT)
        else $error("square root finished outside its wait state");

    // The divider finishes only while the sequencer waits for a quotient.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == psp_pkg::ST_NWAIT || state_reg == psp_pkg::ST_SWAIT
                          || state_reg == psp_pkg::ST_DWAIT))
        else $error("divider finished outside a wait state");

    // A flat pixel carries zero depth and a zero z component.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[124:94] == '0
                                                && m_axis_tdata[47:32] == '0))
        else $error("flat pixel with nonzero depth or z component");

endmodule
